### hw/rtl/krl_pkg.sv
`timescale 1ns / 1ps

package krl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 31;
  localparam int YEAR_W   = 4;
  localparam int AGE_W    = 8;
  localparam int SEX_W    = 2;
  localparam int INIT_W   = 8;
  localparam int STATUS_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_DELETE = 3'd1,
    FN_SEARCH = 3'd2,
    FN_FILTER = 3'd3,
    FN_LIST   = 3'd4,
    FN_CLEAR  = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 4'd0,
    ST_DUP      = 4'd1,
    ST_FULL     = 4'd2,
    ST_REMOVED  = 4'd3,
    ST_NOTFOUND = 4'd4,
    ST_EMPTY    = 4'd5,
    ST_HIT      = 4'd6,
    ST_MISS     = 4'd7,
    ST_RECORD   = 4'd8,
    ST_NOMATCH  = 4'd9,
    ST_CLEARED  = 4'd10
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [YEAR_W-1:0] year;
    logic [AGE_W-1:0]  age;
    logic [SEX_W-1:0]  sex;
    logic              active;
    logic [INIT_W-1:0] initial_code;
  } record_t;

  typedef struct packed {
    status_t status;
    record_t rec;
    logic    last;
  } result_t;

  // Ring control from the sequencer to the row of cells.
  typedef struct packed {
    logic    shift;
    record_t fb;
  } ring_ctl_t;

  function automatic result_t status_result(status_t s);
    result_t r;
    r.status = s;
    r.rec    = '0;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic result_t record_result(record_t rec, logic last);
    result_t r;
    r.status = ST_RECORD;
    r.rec    = rec;
    r.last   = last;
    return r;
  endfunction

endpackage

### hw/rtl/krl_req_if.sv
`timescale 1ns / 1ps

interface krl_req_if;
  import krl_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   student_id;
  logic [YEAR_W-1:0] year;
  logic [AGE_W-1:0]  age;
  logic [SEX_W-1:0]  sex;
  logic              account_active;
  logic [INIT_W-1:0] middle_initial;

  modport source (
    output valid, func, student_id, year, age, sex, account_active, middle_initial,
    input  ready
  );

  modport sink (
    input  valid, func, student_id, year, age, sex, account_active, middle_initial,
    output ready
  );
endinterface

### hw/rtl/krl_res_if.sv
`timescale 1ns / 1ps

interface krl_res_if;
  import krl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     rec_id;
  logic [YEAR_W-1:0]   rec_year;
  logic [AGE_W-1:0]    rec_age;
  logic [SEX_W-1:0]    rec_sex;
  logic                rec_active;
  logic [INIT_W-1:0]   rec_initial;
  logic                last;

  modport source (
    output valid, status, rec_id, rec_year, rec_age, rec_sex, rec_active, rec_initial, last,
    input  ready
  );

  modport sink (
    input  valid, status, rec_id, rec_year, rec_age, rec_sex, rec_active, rec_initial, last,
    output ready
  );
endinterface

### hw/rtl/krl_cell.sv
`timescale 1ns / 1ps

// One slot of the record ring: load the neighbor's record on each shift.
module krl_cell (
  input  logic             clk,
  input  logic             shift,
  input  krl_pkg::record_t d,
  output krl_pkg::record_t q
);

  krl_pkg::record_t rec;

  always_ff @(posedge clk) begin
    if (shift) begin
      rec <= d;
    end
  end

  assign q = rec;

endmodule

### hw/rtl/krl_ctrl.sv
`timescale 1ns / 1ps

module krl_ctrl #(
  parameter int CAPACITY = krl_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  krl_req_if.sink             req,
  krl_res_if.source           res,
  input  krl_pkg::record_t    head,
  input  krl_pkg::record_t    nxt,
  output krl_pkg::ring_ctl_t  ring
);
  import krl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t            state;
  func_t             op;
  logic [ID_W-1:0]   key_id;
  logic [YEAR_W-1:0] key_year;
  record_t           new_rec;
  logic [CW-1:0]     count;
  logic [IW-1:0]     step;
  logic              found;
  logic              pend_v;
  record_t           pend;
  logic              out_valid;
  result_t           res_q;

  logic in_range;
  logic match;
  logic is_read;
  logic hit;
  logic need_emit;
  logic out_free;
  logic step_go;
  logic last_step;
  logic accept;
  func_t req_func;

  always_comb begin
    req_func  = func_t'(req.func);
    in_range  = CW'(step) < count;
    match     = in_range && (head.id == key_id) && !found;
    is_read   = (op == FN_FILTER) || (op == FN_LIST);
    hit       = in_range && ((op == FN_LIST) || (head.year == key_year));
    need_emit = is_read && hit && pend_v;
    out_free  = !out_valid || res.ready;
    step_go   = !need_emit || out_free;
    last_step = step == IW'(CAPACITY - 1);
    accept    = req.valid && req.ready;

    ring.shift = (state == S_WALK) && step_go;
    ring.fb    = head;
    case (op)
      FN_ADD: begin
        // drop the new record into the first free slot as it passes
        if (CW'(step) == count) begin
          ring.fb = new_rec;
        end
      end
      FN_DELETE: begin
        // from the match on, take the neighbor's record to close the gap
        if (found || match) begin
          ring.fb = nxt;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state == S_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      step      <= '0;
      found     <= 1'b0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op                   <= req_func;
            key_id               <= req.student_id;
            key_year             <= req.year;
            new_rec.id           <= req.student_id;
            new_rec.year         <= req.year;
            new_rec.age          <= req.age;
            new_rec.sex          <= req.sex;
            new_rec.active       <= req.account_active;
            new_rec.initial_code <= req.middle_initial;
            step                 <= '0;
            found                <= 1'b0;
            pend_v               <= 1'b0;
            case (req_func)
              FN_ADD, FN_DELETE, FN_SEARCH: begin
                state <= S_WALK;
              end
              FN_FILTER, FN_LIST: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                  res_q     <= status_result(ST_EMPTY);
                end else begin
                  state <= S_WALK;
                end
              end
              FN_CLEAR: begin
                count     <= '0;
                out_valid <= 1'b1;
                res_q     <= status_result(ST_CLEARED);
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (step_go) begin
            found <= found || match;
            if (is_read && hit) begin
              // hold one match back so the final one can carry last
              if (pend_v) begin
                out_valid <= 1'b1;
                res_q     <= record_result(pend, 1'b0);
              end
              pend   <= head;
              pend_v <= 1'b1;
            end
            if (last_step) begin
              step  <= '0;
              state <= S_DONE;
            end else begin
              step <= step + IW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state     <= S_IDLE;
            pend_v    <= 1'b0;
            out_valid <= 1'b1;
            case (op)
              FN_ADD: begin
                if (found) begin
                  res_q <= status_result(ST_DUP);
                end else if (count == CW'(CAPACITY)) begin
                  res_q <= status_result(ST_FULL);
                end else begin
                  count <= count + CW'(1);
                  res_q <= status_result(ST_ADDED);
                end
              end
              FN_DELETE: begin
                if (found) begin
                  count <= count - CW'(1);
                  res_q <= status_result(ST_REMOVED);
                end else begin
                  res_q <= status_result(ST_NOTFOUND);
                end
              end
              FN_SEARCH: begin
                res_q <= status_result(found ? ST_HIT : ST_MISS);
              end
              default: begin
                if (pend_v) begin
                  res_q <= record_result(pend, 1'b1);
                end else begin
                  res_q <= status_result(ST_NOMATCH);
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = res_q.status;
  assign res.rec_id      = res_q.rec.id;
  assign res.rec_year    = res_q.rec.year;
  assign res.rec_age     = res_q.rec.age;
  assign res.rec_sex     = res_q.rec.sex;
  assign res.rec_active  = res_q.rec.active;
  assign res.rec_initial = res_q.rec.initial_code;
  assign res.last        = res_q.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($stable(count) || count == $past(count) + CW'(1) ||
              count == $past(count) - CW'(1) || count == '0))
    else $error("entry count jumped");

  a_ring_restored: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (step == '0))
    else $error("walk ended before a full ring turn");

  a_pend_read_only: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> (op == FN_FILTER || op == FN_LIST))
    else $error("held record outside a read-out");

endmodule

### hw/rtl/keyed_record_list_top.sv
`timescale 1ns / 1ps

// Keyed record list: up to CAPACITY records kept in insertion order in a ring
// of CAPACITY cells. Add, delete and search, and a filter or list all of a
// non-empty list, turn the ring one full revolution, reading the record at
// the head cell, and then give the closing result. The next request can be
// taken in the cycle that this result leaves. A filter or list all stalls
// the turn while it has a record to emit and the result side is busy. Add
// writes the new record into the first free slot as it passes; delete
// closes the gap by feeding the neighbor's record back once the id has
// gone by. Clear, and a read-out of an empty list, answer without turning
// the ring. Filter emits one result per record of the year and list all
// one per record; the last result of every request has last set. Unused
// func codes are accepted and produce nothing. One request is worked at
// a time.
module keyed_record_list_top #(
  parameter int CAPACITY = krl_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  krl_req_if.sink   req,
  krl_res_if.source res
);
  import krl_pkg::*;

  record_t   cell_q [CAPACITY];
  ring_ctl_t ring;

  // Sequencer: handshakes, entry count, head compare and the ring feedback.
  krl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (res),
    .head (cell_q[0]),
    .nxt  (cell_q[1]),
    .ring (ring)
  );

  // Row of cells: each one takes its upper neighbor's record on a shift,
  // the top cell takes the feedback record from the sequencer.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      krl_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (ring.fb),
        .q     (cell_q[i])
      );
    end else begin : g_body
      krl_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

endmodule
